// ===== rtl/core/tplq_pkg.sv =====
// shared types and codes for the three-level priority job queue
package tplq_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int OP_W       = 2;
    localparam int LVL_W      = 2;
    localparam int ST_W       = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT = 2'd2;

    // priority levels
    localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

    // result status
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPRI = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/tplq_ctrl.sv =====
// controller: input handshake and result load sequencing
module tplq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tplq_pkg::t_sts  i_sts,
    output tplq_pkg::t_cmd  o_cmd
);

    tplq_pkg::t_state r_state;
    tplq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tplq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        unique case (r_state)
            tplq_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = tplq_pkg::S_LOAD;
                end
            end
            tplq_pkg::S_LOAD: begin
                // wait for the output register to be free
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = tplq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tplq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tplq_dp.sv =====
// datapath: job store, per-level pointers and counts, result registers
module tplq_dp #(
    parameter int LEVEL_DEPTH = 16,
    parameter int JOB_WIDTH   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tplq_pkg::t_cmd                i_cmd,
    output tplq_pkg::t_sts                o_sts,
    input  logic [tplq_pkg::OP_W-1:0]     i_opcode,
    input  logic [JOB_WIDTH-1:0]          i_job,
    input  logic [tplq_pkg::LVL_W-1:0]    i_priority,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [JOB_WIDTH-1:0]          o_job,
    output logic [tplq_pkg::LVL_W-1:0]    o_level,
    output logic [tplq_pkg::ST_W-1:0]     o_status
);

    localparam int IW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int DEPTH = tplq_pkg::NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [tplq_pkg::LVL_W-1:0] NUM_LVL = tplq_pkg::LVL_W'(tplq_pkg::NUM_LEVELS);

    logic [JOB_WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [JOB_WIDTH-1:0] r_rd_data;

    logic [IW-1:0] r_head  [0:tplq_pkg::NUM_LEVELS-1];
    logic [IW-1:0] r_tail  [0:tplq_pkg::NUM_LEVELS-1];
    logic [CW-1:0] r_count [0:tplq_pkg::NUM_LEVELS-1];

    logic [tplq_pkg::NUM_LEVELS-1:0] full;
    logic [tplq_pkg::NUM_LEVELS-1:0] nonempty;

    logic                       d_write;
    logic                       d_read;
    logic [tplq_pkg::LVL_W-1:0] d_level;
    logic [tplq_pkg::ST_W-1:0]  d_status;
    logic [IW-1:0]              slot;
    logic [IW-1:0]              slot_next;
    logic [AW-1:0]              addr;

    logic                       r_pend_read;
    logic [tplq_pkg::LVL_W-1:0] r_pend_level;
    logic [tplq_pkg::ST_W-1:0]  r_pend_status;

    logic                       r_out_valid;
    logic [JOB_WIDTH-1:0]       r_out_job;
    logic [tplq_pkg::LVL_W-1:0] r_out_level;
    logic [tplq_pkg::ST_W-1:0]  r_out_status;

    always_comb begin
        for (int l = 0; l < tplq_pkg::NUM_LEVELS; l++) begin
            full[l]     = (r_count[l] == CW'(LEVEL_DEPTH));
            nonempty[l] = (r_count[l] != '0);
        end
    end

    // decode of the incoming item
    always_comb begin
        d_write  = 1'b0;
        d_read   = 1'b0;
        d_level  = tplq_pkg::LVL_HIGH;
        d_status = tplq_pkg::ST_BADPRI;
        case (i_opcode)
            tplq_pkg::OP_ADD: begin
                if (i_priority < NUM_LVL) begin
                    d_level = i_priority;
                    if (full[i_priority]) begin
                        d_status = tplq_pkg::ST_FULL;
                    end else begin
                        d_write  = 1'b1;
                        d_status = tplq_pkg::ST_OK;
                    end
                end
            end
            tplq_pkg::OP_TAKE: begin
                if (i_priority < NUM_LVL) begin
                    d_level = i_priority;
                    if (nonempty[i_priority]) begin
                        d_read   = 1'b1;
                        d_status = tplq_pkg::ST_OK;
                    end else begin
                        d_status = tplq_pkg::ST_EMPTY;
                    end
                end
            end
            tplq_pkg::OP_NEXT: begin
                d_status = tplq_pkg::ST_OK;
                d_read   = 1'b1;
                if (nonempty[tplq_pkg::LVL_HIGH]) begin
                    d_level = tplq_pkg::LVL_HIGH;
                end else if (nonempty[tplq_pkg::LVL_MED]) begin
                    d_level = tplq_pkg::LVL_MED;
                end else if (nonempty[tplq_pkg::LVL_LOW]) begin
                    d_level = tplq_pkg::LVL_LOW;
                end else begin
                    d_read   = 1'b0;
                    d_status = tplq_pkg::ST_EMPTY;
                end
            end
            default: begin
                d_status = tplq_pkg::ST_BADPRI;
            end
        endcase
    end

    assign slot      = d_write ? r_tail[d_level] : r_head[d_level];
    assign slot_next = (slot == IW'(LEVEL_DEPTH - 1)) ? '0 : slot + 1'b1;
    assign addr      = AW'(d_level) * AW'(LEVEL_DEPTH) + AW'(slot);

    // job store, one port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && d_write) begin
            r_mem[addr] <= i_job;
        end
        if (i_cmd.accept && d_read) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < tplq_pkg::NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (i_cmd.accept) begin
            if (d_write) begin
                r_tail[d_level]  <= slot_next;
                r_count[d_level] <= r_count[d_level] + 1'b1;
            end else if (d_read) begin
                r_head[d_level]  <= slot_next;
                r_count[d_level] <= r_count[d_level] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_read   <= d_read;
            r_pend_level  <= d_level;
            r_pend_status <= d_status;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_job    <= r_pend_read ? r_rd_data : '0;
            r_out_level  <= r_pend_level;
            r_out_status <= r_pend_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_job    = r_out_job;
    assign o_level  = r_out_level;
    assign o_status = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[0] <= CW'(LEVEL_DEPTH) && r_count[1] <= CW'(LEVEL_DEPTH)
        && r_count[2] <= CW'(LEVEL_DEPTH))
        else $error("level count above depth");

    a_no_load_over_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !i_cmd.load)
        else $error("result loaded over an untaken result");

    a_job_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != tplq_pkg::ST_OK) |-> (r_out_job == '0))
        else $error("job returned with failure status");

    a_read_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && d_read) |-> (r_count[d_level] != '0))
        else $error("read from an empty level");
`endif

endmodule

// ===== rtl/core/three_level_priority_job_queue_unit.sv =====
// top level of the three-level strict-priority job queue
// usage:
//   input stream (s_axis_*): one command per transfer. tdata carries the job
//   number, tuser carries the opcode and the priority level. opcode add puts
//   the job at the tail of its level, take removes the oldest job of the named
//   level, next removes the oldest job of the highest non-empty level.
//   output stream (m_axis_*): exactly one result per command, in order.
//   tdata carries the removed job (zero on add or failure), tuser carries the
//   level and the status (ok, empty, full, invalid priority).
// command flow:
//   a command is decoded, the level pointers are updated and the single-port
//   job store is accessed in the idle state; in the load state, once the
//   output register is free, the result moves into it. a new command is taken
//   only after the load; the store read data is registered, hence that state.
// reset: i_rst_n is synchronous, active low; all levels come up empty, no
//   clearing pass is needed. the job store holds no reset value.
// stall: the output register holds a result until it is taken; one more
//   command can be taken and decoded meanwhile, then s_axis_tready stays low.
module three_level_priority_job_queue_unit #(
    parameter int LEVEL_DEPTH = 16,
    parameter int JOB_WIDTH   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // job_number
    input  logic [((JOB_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // opcode [1:0], priority_level [3:2]
    input  logic [3:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // job_out
    output logic [((JOB_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // level_out [1:0], status [3:2]
    output logic [3:0]                         m_axis_tuser
);

    localparam int DW = ((JOB_WIDTH + 7) / 8) * 8;

    tplq_pkg::t_cmd cmd;
    tplq_pkg::t_sts sts;

    logic [JOB_WIDTH-1:0]              out_job;
    logic [tplq_pkg::LVL_W-1:0]        out_level;
    logic [tplq_pkg::ST_W-1:0]         out_status;

    // command sequencing
    tplq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // queue storage and result path
    tplq_dp #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .JOB_WIDTH   (JOB_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_opcode   (s_axis_tuser[1:0]),
        .i_job      (s_axis_tdata[JOB_WIDTH-1:0]),
        .i_priority (s_axis_tuser[3:2]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_job      (out_job),
        .o_level    (out_level),
        .o_status   (out_status)
    );

    // pad the job to whole bytes
    assign m_axis_tdata = DW'(out_job);
    assign m_axis_tuser = {out_status, out_level};

endmodule

// ===== dv/three_level_priority_job_queue_unit_tb.sv =====
// self-checking testbench for the three-level priority job queue: directed table, then random
module three_level_priority_job_queue_unit_tb;
    import tplq_pkg::*;

    localparam int QDEPTH   = 16;
    localparam int JOB_BITS = 16;

    // codes the package leaves out: the unused opcode and the invalid priority
    localparam logic [OP_W-1:0]  OP_BAD  = 2'd3;
    localparam logic [LVL_W-1:0] LVL_BAD = 2'd3;

    // random items, split into phases that each pick their own mix and idling
    localparam int PHASES        = 37;
    localparam int PHASE_ITEMS   = 50;
    localparam int QUIET_PHASES  = 3;
    localparam int PRESSURE_PH   = 12;
    localparam int MAX_PRINTED   = 100;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // job_number
    logic [JOB_BITS-1:0] s_axis_tdata  = '0;
    // opcode [1:0], priority_level [3:2]
    logic [3:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // job_out
    logic [JOB_BITS-1:0] m_axis_tdata;
    // level_out [1:0], status [3:2]
    logic [3:0]          m_axis_tuser;

    // one result as the block reports it
    typedef struct packed {
        logic [JOB_BITS-1:0] job;
        logic [LVL_W-1:0]    lvl;
        logic [ST_W-1:0]     st;
    } outcome_t;

    // one row of the directed part; reps repeats the command with the job counting up
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [JOB_BITS-1:0] job;
        logic [LVL_W-1:0]    pri;
        logic [4:0]          reps;
        logic                typed;
        logic [JOB_BITS-1:0] e_job;
        logic [LVL_W-1:0]    e_lvl;
        logic [ST_W-1:0]     e_st;
    } directed_row_t;

    // typed results only where they follow at a glance; the rest go through the queue model
    directed_row_t directed_plan [24] = '{
        // everything empty after reset
        '{OP_NEXT, 16'h0000, LVL_HIGH, 5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_EMPTY},
        '{OP_TAKE, 16'hffff, LVL_HIGH, 5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_EMPTY},
        '{OP_TAKE, 16'h0000, LVL_MED,  5'd1,  1'b1, 16'h0000, LVL_MED,  ST_EMPTY},
        '{OP_TAKE, 16'h0000, LVL_LOW,  5'd1,  1'b1, 16'h0000, LVL_LOW,  ST_EMPTY},
        // invalid priority on take and add, then the unused opcode
        '{OP_TAKE, 16'h0000, LVL_BAD,  5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_BADPRI},
        '{OP_ADD,  16'hffff, LVL_BAD,  5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_BADPRI},
        '{OP_BAD,  16'h5a5a, LVL_LOW,  5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_BADPRI},
        // one job per level, then next drains them high first
        '{OP_ADD,  16'hffff, LVL_LOW,  5'd1,  1'b1, 16'h0000, LVL_LOW,  ST_OK},
        '{OP_ADD,  16'h0000, LVL_MED,  5'd1,  1'b1, 16'h0000, LVL_MED,  ST_OK},
        '{OP_ADD,  16'h1234, LVL_HIGH, 5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_OK},
        '{OP_NEXT, 16'h0000, LVL_LOW,  5'd1,  1'b1, 16'h1234, LVL_HIGH, ST_OK},
        '{OP_NEXT, 16'hffff, LVL_HIGH, 5'd1,  1'b1, 16'h0000, LVL_MED,  ST_OK},
        '{OP_NEXT, 16'h0000, LVL_MED,  5'd1,  1'b1, 16'hffff, LVL_LOW,  ST_OK},
        '{OP_NEXT, 16'h0000, LVL_BAD,  5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_EMPTY},
        // fill high and low to the brim, one more add is refused
        '{OP_ADD,  16'ha000, LVL_HIGH, 5'd16, 1'b0, 16'h0000, LVL_HIGH, ST_OK},
        '{OP_ADD,  16'hffff, LVL_HIGH, 5'd1,  1'b1, 16'h0000, LVL_HIGH, ST_FULL},
        '{OP_ADD,  16'h0100, LVL_LOW,  5'd16, 1'b0, 16'h0000, LVL_HIGH, ST_OK},
        '{OP_ADD,  16'h0001, LVL_LOW,  5'd1,  1'b1, 16'h0000, LVL_LOW,  ST_FULL},
        '{OP_ADD,  16'h0002, LVL_MED,  5'd3,  1'b0, 16'h0000, LVL_HIGH, ST_OK},
        // named take passes over a full higher level
        '{OP_TAKE, 16'h0000, LVL_MED,  5'd1,  1'b1, 16'h0002, LVL_MED,  ST_OK},
        '{OP_NEXT, 16'h0000, LVL_HIGH, 5'd16, 1'b0, 16'h0000, LVL_HIGH, ST_OK},
        '{OP_TAKE, 16'h0000, LVL_LOW,  5'd16, 1'b0, 16'h0000, LVL_HIGH, ST_OK},
        '{OP_TAKE, 16'h0000, LVL_LOW,  5'd1,  1'b1, 16'h0000, LVL_LOW,  ST_EMPTY},
        '{OP_NEXT, 16'h0000, LVL_LOW,  5'd3,  1'b0, 16'h0000, LVL_HIGH, ST_OK}
    };

    // queue model state, one fifo per level
    logic [JOB_BITS-1:0] level_jobs [NUM_LEVELS][QDEPTH];
    int                  level_head [NUM_LEVELS];
    int                  level_tail [NUM_LEVELS];
    int                  level_fill [NUM_LEVELS];

    outcome_t pending_outcomes [$];
    int       mismatch_count  = 0;

    // idling knobs, changed per phase; quiet_tail switches all idling off
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    bit quiet_tail     = 1'b0;

    three_level_priority_job_queue_unit #(
        .LEVEL_DEPTH(QDEPTH),
        .JOB_WIDTH  (JOB_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // oldest job of a level that is known to be valid (0..2)
    function automatic outcome_t pop_level(input logic [LVL_W-1:0] lv);
        outcome_t r;
        r = '{job: '0, lvl: lv, st: ST_EMPTY};
        if (level_fill[lv] != 0) begin
            r.job          = level_jobs[lv][level_head[lv]];
            r.st           = ST_OK;
            level_head[lv] = (level_head[lv] + 1) % QDEPTH;
            level_fill[lv]--;
        end
        return r;
    endfunction

    // applies one accepted command to the model and returns the result it must give
    function automatic outcome_t advance_job_queue(input logic [OP_W-1:0] op,
                                                   input logic [JOB_BITS-1:0] job,
                                                   input logic [LVL_W-1:0] pri);
        outcome_t r;
        bit       found;
        r     = '{job: '0, lvl: LVL_HIGH, st: ST_BADPRI};
        found = 1'b0;
        case (op)
            OP_ADD: begin
                if (pri != LVL_BAD) begin
                    r.lvl = pri;
                    if (level_fill[pri] == QDEPTH) begin
                        r.st = ST_FULL;
                    end else begin
                        level_jobs[pri][level_tail[pri]] = job;
                        level_tail[pri] = (level_tail[pri] + 1) % QDEPTH;
                        level_fill[pri]++;
                        r.st = ST_OK;
                    end
                end
            end
            OP_TAKE: begin
                if (pri != LVL_BAD) r = pop_level(pri);
            end
            OP_NEXT: begin
                // strict priority: first non-empty level wins
                r.st = ST_EMPTY;
                for (int lv = 0; lv < NUM_LEVELS; lv++) begin
                    if (!found && level_fill[lv] != 0) begin
                        r     = pop_level(LVL_W'(lv));
                        found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // drive one command, hold it until the transfer, then maybe idle for a burst
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [JOB_BITS-1:0] job,
                            input logic [LVL_W-1:0] pri, input bit use_typed,
                            input outcome_t typed_res);
        outcome_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= job;
        s_axis_tuser  <= {pri, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_job_queue(op, job, pri);
        pending_outcomes.push_back(use_typed ? typed_res : predicted);
        if (!quiet_tail && src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // result side: check each transfer, then stall in random bursts
    initial begin
        int       stall_left;
        outcome_t want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: tdata %h tuser %h",
                                              m_axis_tdata, m_axis_tuser));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_axis_tdata !== want.job)
                        report_mismatch($sformatf("job_out %h, want %h",
                                                  m_axis_tdata, want.job));
                    if (m_axis_tuser[1:0] !== want.lvl)
                        report_mismatch($sformatf("level_out %0d, want %0d (job %h)",
                                                  m_axis_tuser[1:0], want.lvl, want.job));
                    if (m_axis_tuser[3:2] !== want.st)
                        report_mismatch($sformatf("status %0d, want %0d (level %0d)",
                                                  m_axis_tuser[3:2], want.st, want.lvl));
                end
            end
            if (stall_left > 0 && !quiet_tail) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && sink_stall_pct > 0
                         && $urandom_range(99) < sink_stall_pct) begin
                stall_left    = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left    = 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        directed_row_t    row;
        outcome_t         typed_res;
        logic [OP_W-1:0]  op;
        logic [LVL_W-1:0] pri;
        logic [JOB_BITS-1:0] job;
        int               add_pct;
        int               roll;

        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            level_head[lv] = 0;
            level_tail[lv] = 0;
            level_fill[lv] = 0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, mild idling on both sides
        src_gap_pct    = 15;
        sink_stall_pct = 15;
        foreach (directed_plan[i]) begin
            row       = directed_plan[i];
            typed_res = '{job: row.e_job, lvl: row.e_lvl, st: row.e_st};
            for (int k = 0; k < int'(row.reps); k++) begin
                send_cmd(row.op, row.job + JOB_BITS'(k), row.pri, row.typed, typed_res);
            end
        end
        drain_results();

        // random phases: each picks an add share so levels swing between empty and full
        for (int ph = 0; ph < PHASES; ph++) begin
            add_pct        = $urandom_range(15, 85);
            src_gap_pct    = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            sink_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            if (ph >= PHASES - QUIET_PHASES) quiet_tail = 1'b1;
            if (ph == PRESSURE_PH) drain_results();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(99);
                pri  = LVL_W'($urandom_range(2));
                if ($urandom_range(99) < 4) pri = LVL_BAD;
                job  = JOB_BITS'($urandom);
                if (roll < 2)
                    op = OP_BAD;
                else if (roll < add_pct)
                    op = OP_ADD;
                else
                    op = ($urandom_range(1) != 0) ? OP_TAKE : OP_NEXT;
                send_cmd(op, job, pri, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // wait out the last results plus the pipeline, with margin
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
